// ----- hw/rtl/xsr_pkg.sv -----
// Package: shared types, constants and codes of the xoshiro256** uniform range block.
package xsr_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned SPREAD_W    = VAL_W + 1;
  localparam int unsigned MAG_W       = VAL_W - 1;
  localparam int unsigned SEED_COUNT  = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_IDX_LSB = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // xoshiro256** shift and rotate amounts
  localparam int unsigned MUL5_SHIFT = 2;
  localparam int unsigned MUL9_SHIFT = 3;
  localparam int unsigned OUT_ROT    = 7;
  localparam int unsigned T_SHIFT    = 17;
  localparam int unsigned S3_ROT     = 45;

  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  typedef logic [SEED_COUNT-1:0][WORD_W-1:0] seeds_t;

  typedef struct packed {
    logic                    func;
    logic [WORD_W-1:0]       s1;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL5,
    B_MUL9,
    B_ABS,
    B_MULR,
    B_FIN
  } back_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned k);
    rotl = (x << k) | (x >> (WORD_W - k));
  endfunction

endpackage

// ----- hw/rtl/xsr_if.sv -----
// Interfaces: request and result channels with valid/ready handshake.
interface xsr_req_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic signed [xsr_pkg::VAL_W-1:0] range_low;
  logic signed [xsr_pkg::VAL_W-1:0] range_high;

  modport source (output valid, output func, output range_low, output range_high,
                  input ready);
  modport sink   (input valid, input func, input range_low, input range_high,
                  output ready);
endinterface

interface xsr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [xsr_pkg::WORD_W-1:0]       raw_word;
  logic signed [xsr_pkg::VAL_W-1:0] uniform_value;
  logic                             range_error;

  modport source (output valid, output raw_word, output uniform_value,
                  output range_error, input ready);
  modport sink   (input valid, input raw_word, input uniform_value,
                  input range_error, output ready);
endinterface

// ----- hw/rtl/xsr_fifo.sv -----
// Short request queue between the front and back parts.
module xsr_fifo #(
  parameter int unsigned DEPTH = xsr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  xsr_pkg::job_t       push_job,
  input  logic                pop,
  output xsr_pkg::job_t       head_job,
  output xsr_pkg::fifo_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  xsr_pkg::job_t    slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/xsr_front.sv -----
// Front part: accepts requests, advances or reloads the generator state, queues the job.
module xsr_front (
  input  logic                clk,
  input  logic                rst_n,
  xsr_req_if.sink             req,
  input  xsr_pkg::seeds_t     seeds,
  input  xsr_pkg::fifo_stat_t q_stat,
  output logic                push,
  output xsr_pkg::job_t       push_job
);

  logic [xsr_pkg::WORD_W-1:0] s_r   [xsr_pkg::SEED_COUNT];
  logic [xsr_pkg::WORD_W-1:0] s_nxt [xsr_pkg::SEED_COUNT];
  logic [xsr_pkg::WORD_W-1:0] t, s2a, s3a;
  logic                       accept;

  assign req.ready = !q_stat.full;
  assign accept    = req.valid && req.ready;
  assign push      = accept;

  // scrambler input is the pre-advance word 1
  assign push_job.func = req.func;
  assign push_job.s1   = s_r[1];
  assign push_job.lo   = req.range_low;
  assign push_job.hi   = req.range_high;

  always_comb begin
    t   = s_r[1] << xsr_pkg::T_SHIFT;
    s2a = s_r[2] ^ s_r[0];
    s3a = s_r[3] ^ s_r[1];
    for (int i = 0; i < xsr_pkg::SEED_COUNT; i++) begin
      s_nxt[i] = s_r[i];
    end
    if (accept) begin
      if (req.func == xsr_pkg::FUNC_RESEED) begin
        for (int i = 0; i < xsr_pkg::SEED_COUNT; i++) begin
          s_nxt[i] = seeds[i];
        end
      end else begin
        s_nxt[0] = s_r[0] ^ s3a;
        s_nxt[1] = s_r[1] ^ s2a;
        s_nxt[2] = s2a ^ t;
        s_nxt[3] = xsr_pkg::rotl(s3a, xsr_pkg::S3_ROT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < xsr_pkg::SEED_COUNT; i++) begin
        s_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < xsr_pkg::SEED_COUNT; i++) begin
        s_r[i] <= s_nxt[i];
      end
    end
  end

endmodule

// ----- hw/rtl/xsr_back.sv -----
// Back part: scrambles the word, maps it into the range, holds the result register.
module xsr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  xsr_pkg::fifo_stat_t q_stat,
  input  xsr_pkg::job_t       head_job,
  output logic                pop,
  xsr_rsp_if.source           rsp
);

  localparam int unsigned W  = xsr_pkg::WORD_W;
  localparam int unsigned VW = xsr_pkg::VAL_W;
  localparam int unsigned SW = xsr_pkg::SPREAD_W;
  localparam int unsigned MW = xsr_pkg::MAG_W;

  xsr_pkg::back_state_t state_r, state_nxt;
  xsr_pkg::job_t        job_r, job_nxt;
  logic [SW-1:0]        spread_r, spread_nxt;
  logic                 err_r, err_nxt;
  logic [W-1:0]         m5_r, m5_nxt;
  logic [W-1:0]         raw_r, raw_nxt;
  logic [MW-1:0]        mag_r, mag_nxt;
  logic [W-1:0]         prod_r, prod_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [W-1:0]         out_raw_r, out_raw_nxt;
  logic [VW-1:0]        out_uni_r, out_uni_nxt;
  logic                 out_err_r, out_err_nxt;

  logic [W-1:0]  rot;
  logic [VW-1:0] top, neg;
  logic          slot_free;

  assign rsp.valid         = out_valid_r;
  assign rsp.raw_word      = out_raw_r;
  assign rsp.uniform_value = out_uni_r;
  assign rsp.range_error   = out_err_r;
  assign slot_free         = !out_valid_r || rsp.ready;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    spread_nxt    = spread_r;
    err_nxt       = err_r;
    m5_nxt        = m5_r;
    raw_nxt       = raw_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !rsp.ready;
    out_raw_nxt   = out_raw_r;
    out_uni_nxt   = out_uni_r;
    out_err_nxt   = out_err_r;
    pop           = 1'b0;
    rot           = xsr_pkg::rotl(m5_r, xsr_pkg::OUT_ROT);
    top           = raw_r[W-1:W-VW];
    neg           = -top;

    case (state_r)
      xsr_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          // take the head job; span is hi - lo + 1 in 33 bits
          pop        = 1'b1;
          job_nxt    = head_job;
          spread_nxt = {head_job.hi[VW-1], head_job.hi} -
                       {head_job.lo[VW-1], head_job.lo} + SW'(1);
          err_nxt    = (head_job.hi < head_job.lo);
          state_nxt  = xsr_pkg::B_MUL5;
        end
      end
      xsr_pkg::B_MUL5: begin
        m5_nxt    = job_r.s1 + (job_r.s1 << xsr_pkg::MUL5_SHIFT);
        state_nxt = xsr_pkg::B_MUL9;
      end
      xsr_pkg::B_MUL9: begin
        raw_nxt   = rot + (rot << xsr_pkg::MUL9_SHIFT);
        state_nxt = xsr_pkg::B_ABS;
      end
      xsr_pkg::B_ABS: begin
        // magnitude of the signed top half, most negative value saturated
        if (!top[VW-1]) begin
          mag_nxt = top[MW-1:0];
        end else if (neg[VW-1]) begin
          mag_nxt = '1;
        end else begin
          mag_nxt = neg[MW-1:0];
        end
        state_nxt = xsr_pkg::B_MULR;
      end
      xsr_pkg::B_MULR: begin
        prod_nxt  = W'(mag_r) * W'(spread_r);
        state_nxt = xsr_pkg::B_FIN;
      end
      xsr_pkg::B_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (job_r.func == xsr_pkg::FUNC_RESEED) begin
            out_raw_nxt = '0;
            out_uni_nxt = job_r.lo;
            out_err_nxt = 1'b0;
          end else if (err_r) begin
            out_raw_nxt = raw_r;
            out_uni_nxt = job_r.lo;
            out_err_nxt = 1'b1;
          end else begin
            out_raw_nxt = raw_r;
            out_uni_nxt = job_r.lo + prod_r[MW+VW-1:MW];
            out_err_nxt = 1'b0;
          end
          state_nxt = xsr_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = xsr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xsr_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    spread_r  <= spread_nxt;
    err_r     <= err_nxt;
    m5_r      <= m5_nxt;
    raw_r     <= raw_nxt;
    mag_r     <= mag_nxt;
    prod_r    <= prod_nxt;
    out_raw_r <= out_raw_nxt;
    out_uni_r <= out_uni_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule

// ----- hw/rtl/xoshiro256ss_uniform_range.sv -----
// Top level: xoshiro256** generator with uniform range output and seed registers.
//
//   channel  | dir | handshake              | carries
//   ---------+-----+------------------------+------------------------------------
//   in_req   | in  | valid/ready            | func, range_low, range_high
//   out_rsp  | out | valid/ready            | raw_word, uniform_value, range_error
//   cfg_*    | in  | APB write/read, 64 bit | seed_word0..3 at 0x00/0x08/0x10/0x18
//
// The front takes one request per cycle while the queue has room; the state words
// advance (or reload from the seeds) at the accept edge. The back sequencer steps through
// its states for each request (pop, times 5, rotate and times 9, magnitude, range
// multiply, result load), taking the next job only after the result is loaded.
// Reset is synchronous and clears state words, seeds, queue and sequencer.
// A stalled result holds in the output register; the back waits, the queue fills
// and in_req.ready drops once QUEUE_DEPTH requests are waiting.
module xoshiro256ss_uniform_range #(
  parameter int unsigned QUEUE_DEPTH = xsr_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  xsr_req_if.sink                           in_req,
  xsr_rsp_if.source                         out_rsp,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [xsr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [xsr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [xsr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned IDX_W = $clog2(xsr_pkg::SEED_COUNT);

  xsr_pkg::seeds_t     seeds_r;
  xsr_pkg::fifo_stat_t q_stat;
  xsr_pkg::job_t       push_job, head_job;
  logic                push, pop;
  logic [IDX_W-1:0]    cfg_idx;
  logic                cfg_wr;

  // Decode the seed index from the 8-byte register slot; every slot is a seed word.
  assign cfg_idx    = cfg_paddr[xsr_pkg::CFG_IDX_LSB +: IDX_W];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = seeds_r[cfg_idx];

  // Hold seed words until software rewrites them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeds_r <= '0;
    end else if (cfg_wr) begin
      seeds_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // Front: accept request, step the generator, queue the job.
  xsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (in_req),
    .seeds    (seeds_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Queue: decouple acceptance from result delivery.
  xsr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Back: scramble, map into range, drive the result register.
  xsr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head_job (head_job),
    .pop      (pop),
    .rsp      (out_rsp)
  );

endmodule

// ----- hw/rtl/xsr_checker.sv -----
// Checker: port-level assertions on the uniform range block, bound to the top level.
module xsr_checker #(
  parameter int unsigned QUEUE_DEPTH = xsr_pkg::QUEUE_DEPTH
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [xsr_pkg::WORD_W-1:0]       out_raw_word,
  input logic signed [xsr_pkg::VAL_W-1:0] out_uniform_value,
  input logic                             out_range_error
);

  // queue entries plus the sequencer's job plus the result register
  localparam int unsigned CAP   = QUEUE_DEPTH + 2;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = pending_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      pending_nxt = pending_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without an outstanding request");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == CAP_CNT |-> !in_ready)
    else $error("request taken with every slot occupied");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_raw_word) &&
      $stable(out_uniform_value) && $stable(out_range_error))
    else $error("stalled result changed");

endmodule

bind xoshiro256ss_uniform_range xsr_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_xsr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_raw_word      (out_rsp.raw_word),
  .out_uniform_value (out_rsp.uniform_value),
  .out_range_error   (out_rsp.range_error)
);
